>>> design/htw_pkg.sv
// htw_pkg: shared types and constants for the timing wheel
// no dependencies
package htw_pkg;

    localparam int TIMER_SLOTS_DEF = 32;
    localparam int BUCKET_BITS_DEF = 8;
    localparam int LEVEL_COUNT_DEF = 3;
    localparam int SLOT_SHIFT_DEF  = 4;
    localparam int TIME_W  = 48;
    localparam int DELAY_W = 32;
    localparam int ID_W    = 5;

    typedef enum logic [1:0] {
        OP_ADD  = 2'd0,
        OP_NEXT = 2'd1,
        OP_TICK = 2'd2,
        OP_NONE = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_FIRED = 3'd0,
        ST_ADDED = 3'd1,
        ST_RANGE = 3'd2,
        ST_BUSY  = 3'd3,
        ST_DONE  = 3'd4
    } status_t;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [ID_W-1:0]    timer_id;
        logic [DELAY_W-1:0] delay_us;
    } in_word_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [ID_W-1:0]   fired_id;
        logic [TIME_W-1:0] expiry_time;
        logic              last;
    } out_word_t;

    // classified command handed from front to back
    typedef struct packed {
        logic              is_tick;
        logic              is_add;
        logic [2:0]        reject;      // ST_ADDED when accepted
        logic [ID_W-1:0]   id;
        logic [DELAY_W:0]  left;        // remaining time (33 bits)
        logic [DELAY_W:0]  add_amt;     // amount added to current time
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_ADD,
        BK_CASC,
        BK_FIRE0,
        BK_DONE
    } back_state_t;

endpackage

>>> design/htw_front.sv
// htw_front: input word acceptance, opcode decode and delay range check
// depends on htw_pkg
module htw_front #(
    parameter int BUCKET_BITS = 8,
    parameter int LEVEL_COUNT = 3,
    parameter int SLOT_SHIFT  = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  htw_pkg::in_word_t s_data,
    output logic              q_valid,
    input  logic              q_ready,
    output htw_pkg::cmd_t     q_cmd
);
    import htw_pkg::*;

    localparam int LIM_BIT = SLOT_SHIFT + LEVEL_COUNT * BUCKET_BITS;
    localparam int SLOT_US = 1 << SLOT_SHIFT;

    logic q_valid_reg, q_valid_next;
    cmd_t q_cmd_reg, q_cmd_next;
    logic too_big;

    assign s_ready = !q_valid_reg || q_ready;
    assign q_valid = q_valid_reg;
    assign q_cmd   = q_cmd_reg;

    // delay at or above the wheel span
    always_comb begin
        if (LIM_BIT >= DELAY_W) too_big = 1'b0;
        else too_big = (s_data.delay_us >> LIM_BIT) != '0;
    end

    // classify the incoming word
    always_comb begin
        q_cmd_next = q_cmd_reg;
        q_valid_next = q_valid_reg;
        if (q_valid_reg && q_ready) q_valid_next = 1'b0;
        if (s_valid && s_ready) begin
            q_cmd_next.is_tick = s_data.opcode == OP_TICK;
            q_cmd_next.is_add  = s_data.opcode == OP_ADD || s_data.opcode == OP_NEXT;
            q_cmd_next.id      = s_data.timer_id;
            q_cmd_next.reject  = ST_ADDED;
            if (s_data.opcode == OP_ADD) begin
                q_cmd_next.left    = {1'b0, s_data.delay_us};
                q_cmd_next.add_amt = {1'b0, s_data.delay_us} + (DELAY_W+1)'(SLOT_US - 1);
                if (s_data.delay_us == '0 || too_big) q_cmd_next.reject = ST_RANGE;
            end else begin
                q_cmd_next.left    = (DELAY_W+1)'(SLOT_US);
                q_cmd_next.add_amt = (DELAY_W+1)'(SLOT_US);
            end
            q_valid_next = s_data.opcode != OP_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_valid_reg <= 1'b0;
        end else begin
            q_valid_reg <= q_valid_next;
        end
        q_cmd_reg <= q_cmd_next;
    end
endmodule

>>> design/htw_back.sv
// htw_back: timer table, adds, cascade and level-0 scan, result register
// depends on htw_pkg
module htw_back #(
    parameter int TIMER_SLOTS = 32,
    parameter int BUCKET_BITS = 8,
    parameter int LEVEL_COUNT = 3,
    parameter int SLOT_SHIFT  = 4
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [htw_pkg::TIME_W-1:0] cfg_wr_data,
    input  logic                      q_valid,
    output logic                      q_ready,
    input  htw_pkg::cmd_t             q_cmd,
    output logic                      m_valid,
    input  logic                      m_ready,
    output htw_pkg::out_word_t        m_data
);
    import htw_pkg::*;

    localparam int SW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int LW = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;
    localparam int SLOT_US = 1 << SLOT_SHIFT;

    back_state_t state_reg, state_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic [TIMER_SLOTS-1:0] act_reg, act_next;
    logic [TIME_W-1:0] exp_mem [TIMER_SLOTS];
    logic [LW-1:0] lvl_mem [TIMER_SLOTS];
    logic [BUCKET_BITS-1:0] bkt_mem [TIMER_SLOTS];
    logic [SW-1:0] idx_reg, idx_next;
    logic [LW-1:0] cl_reg, cl_next;
    cmd_t cmd_reg, cmd_next;
    logic ov_reg, ov_next;
    out_word_t od_reg, od_next;

    // table write port
    logic wr_en;
    logic [SW-1:0] wr_idx;
    logic [TIME_W-1:0] wr_exp;
    logic [LW-1:0] wr_lvl;
    logic [BUCKET_BITS-1:0] wr_bkt;

    function automatic logic [BUCKET_BITS-1:0] offs(input logic [TIME_W-1:0] t,
                                                    input int l);
        logic [TIME_W-1:0] s;
        s = t >> (l * BUCKET_BITS + SLOT_SHIFT);
        return s[BUCKET_BITS-1:0];
    endfunction

    // level from the leading bit of the remaining time, saturated
    function automatic logic [LW-1:0] lvl_of(input logic [TIME_W-1:0] left);
        logic [TIME_W-1:0] v;
        logic [LW-1:0] r;
        v = left | TIME_W'(SLOT_US);
        r = '0;
        for (int l = 1; l < LEVEL_COUNT; l++) begin
            if ((v >> (l * BUCKET_BITS + SLOT_SHIFT)) != '0) r = LW'(l);
        end
        return r;
    endfunction

    logic [TIME_W-1:0] add_exp, cur_exp, rem;
    logic [LW-1:0] add_lvl, re_lvl;
    logic hit, last_idx, casc_more;
    logic id_ok;
    logic out_free;

    assign out_free = !ov_reg || m_ready;
    assign m_valid  = ov_reg;
    assign m_data   = od_reg;
    assign add_exp  = now_reg + TIME_W'(cmd_reg.add_amt);
    assign add_lvl  = lvl_of(TIME_W'(cmd_reg.left));
    assign cur_exp  = exp_mem[idx_reg];
    assign rem      = cur_exp - now_reg;
    assign re_lvl   = lvl_of(rem);
    assign last_idx = idx_reg == SW'(TIMER_SLOTS - 1);
    assign id_ok    = ({1'b0, cmd_reg.id} < (ID_W+1)'(TIMER_SLOTS));
    assign q_ready  = state_reg == BK_IDLE;
    assign casc_more = (int'(cl_reg) + 1 < LEVEL_COUNT) &&
                       (offs(now_reg, int'(cl_reg)) == '0);

    always_comb begin
        hit = 1'b0;
        if (state_reg == BK_CASC)
            hit = act_reg[idx_reg] && lvl_mem[idx_reg] == cl_reg &&
                  bkt_mem[idx_reg] == offs(now_reg, int'(cl_reg));
        else if (state_reg == BK_FIRE0)
            hit = act_reg[idx_reg] && lvl_mem[idx_reg] == '0 &&
                  bkt_mem[idx_reg] == offs(now_reg, 0);
    end

    // sequencer: one slot per cycle in scans, held on a result stall
    always_comb begin
        state_next = state_reg;
        now_next = now_reg;
        act_next = act_reg;
        idx_next = idx_reg;
        cl_next = cl_reg;
        cmd_next = cmd_reg;
        ov_next = ov_reg && !m_ready;
        od_next = od_reg;
        wr_en = 1'b0;
        wr_idx = idx_reg;
        wr_exp = cur_exp;
        wr_lvl = re_lvl;
        wr_bkt = offs(cur_exp, int'(re_lvl));
        case (state_reg)
            BK_IDLE: begin
                if (q_valid) begin
                    cmd_next = q_cmd;
                    idx_next = '0;
                    if (q_cmd.is_tick) begin
                        if (LEVEL_COUNT > 1 && offs(now_reg, 0) == '0) begin
                            cl_next = LW'(1);
                            state_next = BK_CASC;
                        end else begin
                            state_next = BK_FIRE0;
                        end
                    end else begin
                        state_next = BK_ADD;
                    end
                end
            end
            BK_ADD: begin
                if (out_free) begin
                    ov_next = 1'b1;
                    od_next.fired_id = cmd_reg.id;
                    od_next.last = 1'b1;
                    od_next.expiry_time = '0;
                    if (cmd_reg.reject == ST_RANGE) begin
                        od_next.status = ST_RANGE;
                    end else if (!id_ok || act_reg[SW'(cmd_reg.id)]) begin
                        od_next.status = ST_BUSY;
                    end else begin
                        od_next.status = ST_ADDED;
                        od_next.expiry_time = add_exp;
                        wr_en = 1'b1;
                        wr_idx = SW'(cmd_reg.id);
                        wr_exp = add_exp;
                        wr_lvl = add_lvl;
                        wr_bkt = offs(add_exp, int'(add_lvl));
                        act_next[SW'(cmd_reg.id)] = 1'b1;
                    end
                    state_next = BK_IDLE;
                end
            end
            BK_CASC: begin
                if (!hit || cur_exp > now_reg || out_free) begin
                    if (hit) begin
                        if (cur_exp <= now_reg) begin
                            act_next[idx_reg] = 1'b0;
                            ov_next = 1'b1;
                            od_next = '{ST_FIRED, ID_W'(idx_reg), cur_exp, 1'b0};
                        end else begin
                            wr_en = 1'b1;
                        end
                    end
                    idx_next = idx_reg + 1'b1;
                    if (last_idx) begin
                        idx_next = '0;
                        if (casc_more) cl_next = cl_reg + 1'b1;
                        else state_next = BK_FIRE0;
                    end
                end
            end
            BK_FIRE0: begin
                if (!hit || out_free) begin
                    if (hit) begin
                        act_next[idx_reg] = 1'b0;
                        ov_next = 1'b1;
                        od_next = '{ST_FIRED, ID_W'(idx_reg), cur_exp, 1'b0};
                    end
                    idx_next = idx_reg + 1'b1;
                    if (last_idx) begin
                        idx_next = '0;
                        state_next = BK_DONE;
                    end
                end
            end
            BK_DONE: begin
                if (out_free) begin
                    ov_next = 1'b1;
                    od_next = '{ST_DONE, '0, now_reg, 1'b1};
                    now_next = now_reg + TIME_W'(SLOT_US);
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
        if (cfg_wr_en) now_next = cfg_wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
            now_reg <= '0;
            act_reg <= '0;
            ov_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            now_reg <= now_next;
            act_reg <= act_next;
            ov_reg <= ov_next;
        end
        idx_reg <= idx_next;
        cl_reg <= cl_next;
        cmd_reg <= cmd_next;
        od_reg <= od_next;
    end

    // timer table
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            exp_mem[wr_idx] <= wr_exp;
            lvl_mem[wr_idx] <= wr_lvl;
            bkt_mem[wr_idx] <= wr_bkt;
        end
    end
endmodule

>>> design/hierarchical_timer_wheel.sv
// Three-level timing wheel for up to TIMER_SLOTS timers. A tick walks the
// timer table one slot per cycle, and holds while the result side stalls:
// a pass for each level that cascades, then a pass for the level-0 bucket,
// then the done word. The front decode stage holds one word so the next
// item waits there while the back end works.
// top level; depends on htw_pkg, htw_front, htw_back
module hierarchical_timer_wheel #(
    parameter int TIMER_SLOTS = htw_pkg::TIMER_SLOTS_DEF,
    parameter int BUCKET_BITS = htw_pkg::BUCKET_BITS_DEF,
    parameter int LEVEL_COUNT = htw_pkg::LEVEL_COUNT_DEF,
    parameter int SLOT_SHIFT  = htw_pkg::SLOT_SHIFT_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [htw_pkg::TIME_W-1:0] cfg_wr_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  htw_pkg::in_word_t          s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output htw_pkg::out_word_t         m_data
);
    import htw_pkg::*;

    logic q_valid, q_ready;
    cmd_t q_cmd;

    htw_front #(.BUCKET_BITS(BUCKET_BITS), .LEVEL_COUNT(LEVEL_COUNT),
                .SLOT_SHIFT(SLOT_SHIFT)) u_front (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_data(s_data), .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
    );

    htw_back #(.TIMER_SLOTS(TIMER_SLOTS), .BUCKET_BITS(BUCKET_BITS),
               .LEVEL_COUNT(LEVEL_COUNT), .SLOT_SHIFT(SLOT_SHIFT)) u_back (
        .aclk(aclk), .aresetn(aresetn), .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data), .q_valid(q_valid), .q_ready(q_ready),
        .q_cmd(q_cmd), .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );
endmodule

>>> design/htw_checker.sv
// htw_checker: port-level checks on the timing wheel, bound to the top level
// depends on htw_pkg
module htw_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input htw_pkg::out_word_t m_data
);
    import htw_pkg::*;

    // result word holds while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // add results and the done word carry last
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == ST_ADDED || m_data.status == ST_RANGE ||
                    m_data.status == ST_BUSY || m_data.status == ST_DONE)
        |-> m_data.last)
        else $error("last missing");

    // a fired word never ends an item
    a_fired: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ST_FIRED |-> !m_data.last)
        else $error("fired with last");

    // status codes stay in range
    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.status <= ST_DONE)
        else $error("bad status");
endmodule

bind hierarchical_timer_wheel htw_checker u_htw_checker (
    .aclk(aclk), .aresetn(aresetn), .m_valid(m_valid), .m_ready(m_ready),
    .m_data(m_data)
);
